>>> rtl/alubcd_pkg.sv
// Package for the eight-bit ALU with decimal add/subtract.
// Holds the request/response types, operation codes, flag positions and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alubcd_pkg;

	localparam logic [3:0] KIND_ADC  = 4'd0;
	localparam logic [3:0] KIND_SBC  = 4'd1;
	localparam logic [3:0] KIND_AND  = 4'd2;
	localparam logic [3:0] KIND_ORA  = 4'd3;
	localparam logic [3:0] KIND_EOR  = 4'd4;
	localparam logic [3:0] KIND_CMP  = 4'd5;
	localparam logic [3:0] KIND_BIT  = 4'd6;
	localparam logic [3:0] KIND_ASL  = 4'd7;
	localparam logic [3:0] KIND_LSR  = 4'd8;
	localparam logic [3:0] KIND_ROL  = 4'd9;
	localparam logic [3:0] KIND_ROR  = 4'd10;
	localparam logic [3:0] KIND_INC  = 4'd11;
	localparam logic [3:0] KIND_DEC  = 4'd12;
	localparam logic [3:0] KIND_LOAD = 4'd13;

	// status bit positions
	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_D = 3;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam logic [3:0] DIGIT_MAX   = 4'd9;
	localparam logic [8:0] DEC_LIMIT   = 9'd99;
	localparam logic [8:0] DEC_ONE_H   = 9'd100;
	localparam logic [8:0] DEC_TWO_H   = 9'd200;
	localparam logic [8:0] DEC_THREE_H = 9'd300;
	// tens = (m * 205) >> 11 holds for m below 100
	localparam logic [14:0] TENS_RECIP = 15'd205;
	localparam int          TENS_SHIFT = 11;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] register_value;
		logic [7:0] operand;
		logic [7:0] status_in;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] status_out;
	} alu_rsp_t;

	function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] val);
		logic [7:0] s;
		s = st;
		s[FL_N] = val[7];
		s[FL_Z] = (val == 8'd0);
		return s;
	endfunction

	// lo + 10*hi, nibbles taken as they are
	function automatic logic [7:0] digit_weight(input logic [7:0] x);
		return 8'({x[7:4], 3'b000}) + 8'({x[7:4], 1'b0}) + 8'(x[3:0]);
	endfunction

	function automatic logic overflow(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] r);
		return (a[7] == b[7]) && (a[7] != r[7]);
	endfunction

endpackage

`default_nettype wire

>>> rtl/eight_bit_alu_with_bcd.sv
// Top level of the eight-bit ALU with decimal add/subtract.
// Three-stage pipeline; uses types, codes and helpers from alubcd_pkg.
//
// Usage:
//   A request (req) is taken at any rising edge where start is high and
//   busy is low. busy is held low: a new request may enter every cycle.
//   The response (rsp) appears, through stage registers s1, s2 and s3,
//   on the cycle that done is high, for exactly one cycle; the receiver
//   cannot hold it off. Throughput is one request per cycle. The stages
//   are operand preparation (complement, digit weighting), the two adders
//   with the other operations, and decimal correction (mod 100, digit
//   split) with flag assembly. Requests leave in the order they entered.
//   Reset clears the stage valid bits; no response is pending afterwards.
//   Kinds 14 and 15 return register_value and the status unchanged.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_bcd (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire alubcd_pkg::alu_req_t  req,
	output logic                       done,
	output alubcd_pkg::alu_rsp_t       rsp
);
	import alubcd_pkg::*;

	// stage 1: prepared operands
	logic       v_s1;
	logic [3:0] kind_s1;
	logic [7:0] a_s1, op_s1, b_s1, st_s1, av_s1, bv_s1;
	logic       cin_s1, dec_s1;

	// stage 2: sums and simple results
	logic       v_s2;
	logic [3:0] kind_s2;
	logic [7:0] a_s2, b_s2, st_s2, res_misc_s2, sto_misc_s2;
	logic [8:0] sum_bin_s2, sum_dec_s2;
	logic       dec_s2;

	// stage 3: response register
	logic       v_s3;
	alu_rsp_t   rsp_s3;

	logic       accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---- stage A: operand preparation
	logic       is_sub, is_cmp, is_dec;
	logic [3:0] lo_c, hi_c;
	logic [7:0] b_dec, b_bin;

	always_comb begin
		is_sub = (req.kind == KIND_SBC);
		is_cmp = (req.kind == KIND_CMP);
		is_dec = req.status_in[FL_D] && ((req.kind == KIND_ADC) || is_sub);
		lo_c   = is_sub ? 4'(DIGIT_MAX - req.operand[3:0]) : req.operand[3:0];
		hi_c   = is_sub ? 4'(DIGIT_MAX - req.operand[7:4]) : req.operand[7:4];
		b_dec  = {hi_c, lo_c};
		b_bin  = (is_sub || is_cmp) ? ~req.operand : req.operand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= req.kind;
		a_s1    <= req.register_value;
		op_s1   <= req.operand;
		st_s1   <= req.status_in;
		b_s1    <= is_dec ? b_dec : b_bin;
		av_s1   <= digit_weight(req.register_value);
		bv_s1   <= digit_weight(b_dec);
		cin_s1  <= is_cmp ? 1'b1 : req.status_in[FL_C];
		dec_s1  <= is_dec;
	end

	// ---- stage B: adders and the non-arithmetic operations
	logic [7:0] res_misc, sto_misc;

	always_comb begin
		res_misc = a_s1;
		sto_misc = st_s1;
		unique case (kind_s1)
			KIND_AND: begin
				res_misc = a_s1 & op_s1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			KIND_ORA: begin
				res_misc = a_s1 | op_s1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			KIND_EOR: begin
				res_misc = a_s1 ^ op_s1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			KIND_BIT: begin
				sto_misc       = st_s1;
				sto_misc[FL_Z] = ((a_s1 & op_s1) == 8'd0);
				sto_misc[FL_N] = op_s1[7];
				sto_misc[FL_V] = op_s1[6];
			end
			KIND_ASL, KIND_ROL: begin
				res_misc       = {op_s1[6:0], (kind_s1 == KIND_ROL) & st_s1[FL_C]};
				sto_misc       = set_nz(st_s1, res_misc);
				sto_misc[FL_C] = op_s1[7];
			end
			KIND_LSR, KIND_ROR: begin
				res_misc       = {(kind_s1 == KIND_ROR) & st_s1[FL_C], op_s1[7:1]};
				sto_misc       = set_nz(st_s1, res_misc);
				sto_misc[FL_C] = op_s1[0];
			end
			KIND_INC: begin
				res_misc = op_s1 + 8'd1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			KIND_DEC: begin
				res_misc = op_s1 - 8'd1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			KIND_LOAD: begin
				res_misc = op_s1;
				sto_misc = set_nz(st_s1, res_misc);
			end
			default: begin
				res_misc = a_s1;
				sto_misc = st_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2     <= kind_s1;
		a_s2        <= a_s1;
		b_s2        <= b_s1;
		st_s2       <= st_s1;
		dec_s2      <= dec_s1;
		sum_bin_s2  <= 9'(a_s1) + 9'(b_s1) + 9'(cin_s1);
		sum_dec_s2  <= 9'(av_s1) + 9'(bv_s1) + 9'(cin_s1);
		res_misc_s2 <= res_misc;
		sto_misc_s2 <= sto_misc;
	end

	// ---- stage C: decimal correction and flags
	logic [8:0]  m9;
	logic [6:0]  m;
	logic [14:0] tens_prod;
	logic [3:0]  tens, ones;
	logic [6:0]  ones_w;
	logic [7:0]  add_r, sto_add;
	logic        add_c;
	alu_rsp_t    rsp_c;

	always_comb begin
		// decimal sum is at most 331
		priority if (sum_dec_s2 >= DEC_THREE_H) begin
			m9 = sum_dec_s2 - DEC_THREE_H;
		end else if (sum_dec_s2 >= DEC_TWO_H) begin
			m9 = sum_dec_s2 - DEC_TWO_H;
		end else if (sum_dec_s2 >= DEC_ONE_H) begin
			m9 = sum_dec_s2 - DEC_ONE_H;
		end else begin
			m9 = sum_dec_s2;
		end
		m         = m9[6:0];
		tens_prod = 15'(m) * TENS_RECIP;
		tens      = tens_prod[TENS_SHIFT +: 4];
		ones_w    = m - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
		ones      = ones_w[3:0];

		add_r = dec_s2 ? {tens, ones} : sum_bin_s2[7:0];
		add_c = dec_s2 ? (sum_dec_s2 > DEC_LIMIT) : sum_bin_s2[8];
		sto_add       = set_nz(st_s2, add_r);
		sto_add[FL_C] = add_c;
		sto_add[FL_V] = overflow(a_s2, b_s2, add_r);

		rsp_c.result     = res_misc_s2;
		rsp_c.status_out = sto_misc_s2;
		if ((kind_s2 == KIND_ADC) || (kind_s2 == KIND_SBC)) begin
			rsp_c.result     = add_r;
			rsp_c.status_out = sto_add;
		end else if (kind_s2 == KIND_CMP) begin
			rsp_c.result           = a_s2;
			rsp_c.status_out       = set_nz(st_s2, sum_bin_s2[7:0]);
			rsp_c.status_out[FL_C] = sum_bin_s2[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s3 <= rsp_c;
	end

	assign done = v_s3;
	assign rsp  = rsp_s3;

	// ---- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted request did not complete after three cycles");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && dec_s2) |=> ((rsp.result[3:0] <= DIGIT_MAX) && (rsp.result[7:4] <= DIGIT_MAX)))
		else $error("decimal result holds a non-BCD digit");

	a_cmp_keeps_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (kind_s2 == KIND_CMP)) |=> (rsp.result == $past(a_s2)))
		else $error("compare changed the register value");

	a_d_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> (rsp.status_out[FL_D] == $past(st_s2[FL_D])))
		else $error("decimal flag altered");

endmodule

`default_nettype wire
